>>> src/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// overlapped implication, checked on the same clock edge
`define ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication on the next clock edge
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> src/gpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Guide PID limiter package
// Types, register indexes and fixed widths shared by the guide controller.
// ----------------------------------------------------------------------------
package gpl_pkg;

	localparam int CORR_W = 43;
	localparam int SUM_W = 67;
	localparam logic [1:0] CLAMP_RUN_LIMIT = 2'd3;

	localparam logic [5:0] MUL_LAST = 6'd31;
	localparam logic [5:0] DIV_LAST = 6'd40;

	localparam logic [3:0] REG_MODE = 4'd0;
	localparam logic [3:0] REG_PGAIN = 4'd1;
	localparam logic [3:0] REG_IGAIN = 4'd2;
	localparam logic [3:0] REG_DGAIN = 4'd3;
	localparam logic [3:0] REG_REF = 4'd4;
	localparam logic [3:0] REG_RACOEF = 4'd5;
	localparam logic [3:0] REG_DECCOEF = 4'd6;
	localparam logic [3:0] REG_LIMITS = 4'd7;

	localparam logic [3:0] OP_P_RA = 4'd0;
	localparam logic [3:0] OP_I_RA = 4'd1;
	localparam logic [3:0] OP_D_RA = 4'd2;
	localparam logic [3:0] OP_P_DEC = 4'd3;
	localparam logic [3:0] OP_I_DEC = 4'd4;
	localparam logic [3:0] OP_D_DEC = 4'd5;
	localparam logic [3:0] OP_RA_SL = 4'd6;
	localparam logic [3:0] OP_RA_CN = 4'd7;
	localparam logic [3:0] OP_DEC_SL = 4'd8;
	localparam logic [3:0] OP_DEC_CN = 4'd9;
	localparam logic [3:0] OP_DIV_RA = 4'd0;
	localparam logic [3:0] OP_DIV_DEC = 4'd1;

	localparam logic [1:0] DIR_POS = 2'b01;
	localparam logic [1:0] DIR_ZERO = 2'b00;
	localparam logic [1:0] DIR_NEG = 2'b11;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LOAD = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_ACC  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	typedef logic [1:0] dir_t;

	function automatic dir_t sgn_corr(input logic signed [CORR_W-1:0] v);
		dir_t r;
		if (v == '0) r = DIR_ZERO;
		else if (v[CORR_W-1]) r = DIR_NEG;
		else r = DIR_POS;
		return r;
	endfunction

	function automatic dir_t dir_mul(input dir_t a, input dir_t b);
		dir_t r;
		if (a == DIR_ZERO || b == DIR_ZERO) r = DIR_ZERO;
		else if (a == b) r = DIR_POS;
		else r = DIR_NEG;
		return r;
	endfunction

	function automatic dir_t dir_neg(input dir_t a);
		dir_t r;
		if (a == DIR_POS) r = DIR_NEG;
		else if (a == DIR_NEG) r = DIR_POS;
		else r = DIR_ZERO;
		return r;
	endfunction

endpackage

>>> src/two_axis_guide_pid_limiter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-axis guide PID limiter
// Guide loop controller: PID or slope mode, 2x2 mapping, step clamp, lost guide.
// ----------------------------------------------------------------------------
// Usage:
//  sample channel (sample_valid/sample_stall) carries one RA/DEC mean pair.
//  result channel (result_valid/result_stall) returns one correction item.
//  cfg channel (cfg_valid/cfg_ready, always ready) writes registers by index;
//  write only while no item is in flight.
//  PID mode: ten 32x48 products on one bit-serial multiplier, each made of a
//  load, shift-add steps and an accumulate step. Slope mode: two restoring
//  divisions, each a load, shift-subtract steps and an accumulate step.
//  One item at a time: sample_stall is high from accept until the result is
//  loaded into the output register; the next item can be taken once the
//  block is back in idle.
//  A stalled result holds in the output register; the block then waits at the
//  final step until it is taken.
//  Reset loads register defaults, clears integrals, last errors and run counts
//  and sets the previous directions to minus one.
module two_axis_guide_pid_limiter_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic signed [31:0] ra_mean,
	input  logic signed [31:0] dec_mean,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [31:0]        ra_steps,
	output gpl_pkg::dir_t      ra_direction,
	output logic [31:0]        dec_steps,
	output gpl_pkg::dir_t      dec_direction,
	output logic               lost_guide,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [63:0]        cfg_data
);
	import gpl_pkg::*;
`include "assert_macros.svh"

	state_t state_q;

	logic        mode_q;
	logic [31:0] pgain_q, igain_q, dgain_q;
	logic [63:0] ref_q, racoef_q, deccoef_q, limits_q;

	logic signed [47:0] integ_ra_q, integ_dec_q;
	logic signed [31:0] last_ra_q, last_dec_q;
	logic [1:0]         run_ra_q, run_dec_q;
	dir_t               ldir_ra_q, ldir_dec_q;

	logic signed [31:0] e_ra_q, e_dec_q;
	logic signed [32:0] d_ra_q, d_dec_q;
	logic signed [32:0] diff_ra_q, diff_dec_q;
	logic signed [31:0] u_ra_q, u_dec_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [CORR_W-1:0] corr_ra_q, corr_dec_q;
	logic [3:0] op_q;
	logic [5:0] cnt_q;

	logic [31:0]        g_sh_q;
	logic signed [48:0] acc_hi_q;
	logic [31:0]        acc_lo_q;
	logic [40:0]        quo_q;
	logic [31:0]        rem_q;
	logic [31:0]        divisor_q;
	logic               dneg_q;

	logic signed [31:0] ref_ra, ref_dec;
	logic signed [31:0] ra_sl, ra_cn, dec_sl, dec_cn;
	assign ref_ra = ref_q[31:0];
	assign ref_dec = ref_q[63:32];
	assign ra_sl = racoef_q[31:0];
	assign ra_cn = racoef_q[63:32];
	assign dec_sl = deccoef_q[31:0];
	assign dec_cn = deccoef_q[63:32];

	logic accept;
	assign sample_stall = (state_q != ST_IDLE);
	assign accept = sample_valid && !sample_stall;
	assign cfg_ready = 1'b1;

	// front end of the PID step
	logic signed [32:0] e_ra_w, e_dec_w, dra_w, ddec_w;
	logic signed [31:0] es_ra, es_dec;
	logic signed [48:0] ir_w, id_w;
	logic signed [47:0] is_ra, is_dec;

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v > 33'sd2147483647) r = 32'sh7fffffff;
		else if (v < -33'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
		logic signed [47:0] r;
		if (v[48] != v[47]) r = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		else r = v[47:0];
		return r;
	endfunction

	always_comb begin
		e_ra_w = 33'(ref_ra) - 33'(ra_mean);
		e_dec_w = 33'(ref_dec) - 33'(dec_mean);
		es_ra = sat32(e_ra_w);
		es_dec = sat32(e_dec_w);
		ir_w = 49'(integ_ra_q) + 49'(es_ra);
		id_w = 49'(integ_dec_q) + 49'(es_dec);
		is_ra = sat48(ir_w);
		is_dec = sat48(id_w);
		dra_w = 33'(es_ra) - 33'(last_ra_q);
		ddec_w = 33'(es_dec) - 33'(last_dec_q);
	end

	// operand selection for the shared multiplier
	logic [31:0]        g_sel;
	logic signed [47:0] x_sel;
	always_comb begin
		case (op_q)
			OP_P_RA: begin g_sel = pgain_q; x_sel = 48'(e_ra_q); end
			OP_I_RA: begin g_sel = igain_q; x_sel = integ_ra_q; end
			OP_D_RA: begin g_sel = dgain_q; x_sel = 48'(d_ra_q); end
			OP_P_DEC: begin g_sel = pgain_q; x_sel = 48'(e_dec_q); end
			OP_I_DEC: begin g_sel = igain_q; x_sel = integ_dec_q; end
			OP_D_DEC: begin g_sel = dgain_q; x_sel = 48'(d_dec_q); end
			OP_RA_SL: begin g_sel = ra_sl; x_sel = 48'(u_ra_q); end
			OP_RA_CN: begin g_sel = ra_cn; x_sel = 48'(u_dec_q); end
			OP_DEC_SL: begin g_sel = dec_sl; x_sel = 48'(u_ra_q); end
			OP_DEC_CN: begin g_sel = dec_cn; x_sel = 48'(u_dec_q); end
			default: begin g_sel = '0; x_sel = '0; end
		endcase
	end

	// shift-add step, sign bit of g weighs negative
	logic signed [49:0] addend, msum;
	always_comb begin
		if (!g_sh_q[0]) addend = '0;
		else if (cnt_q == MUL_LAST) addend = -50'(x_sel);
		else addend = 50'(x_sel);
		msum = 50'(acc_hi_q) + addend;
	end

	// restoring divider step
	logic [32:0] dshift, dtrial;
	logic        dge;
	always_comb begin
		dshift = {rem_q, quo_q[40]};
		dtrial = dshift - {1'b0, divisor_q};
		dge = (dshift >= {1'b0, divisor_q});
	end

	// divider load values
	logic signed [40:0] dnum;
	logic signed [31:0] dslope;
	always_comb begin
		dnum = (op_q == OP_DIV_RA) ? {diff_ra_q, 8'd0} : {diff_dec_q, 8'd0};
		dslope = (op_q == OP_DIV_RA) ? ra_sl : dec_sl;
	end

	// accumulate step
	logic signed [80:0]       prod;
	logic signed [SUM_W-1:0]  term, nsum, nabs;
	logic [CORR_W-1:0]        cmag;
	logic signed [CORR_W-1:0] counts, qcorr;
	logic signed [31:0]       usat;
	always_comb begin
		prod = {acc_hi_q, acc_lo_q};
		if (op_q < OP_RA_SL) term = SUM_W'($signed(prod[80:16]));
		else term = SUM_W'($signed(prod[63:0]));
		nsum = sum_q + term;
		if (nsum > 67'sd2147483647) usat = 32'sd2147483647;
		else if (nsum < -67'sd2147483647) usat = -32'sd2147483647;
		else usat = nsum[31:0];
		nabs = nsum[SUM_W-1] ? -nsum : nsum;
		cmag = nabs[SUM_W-1:24];
		counts = nsum[SUM_W-1] ? -$signed(cmag) : $signed(cmag);
		if (dslope == '0) qcorr = '0;
		else if (dneg_q) qcorr = -$signed({2'b00, quo_q});
		else qcorr = $signed({2'b00, quo_q});
	end

	// clamp and lost guide
	dir_t               fdir_ra, fdir_dec;
	logic [CORR_W-1:0]  fmag_ra, fmag_dec;
	logic               fcl_ra, fcl_dec, flost;
	logic [1:0]         frun_ra, frun_dec;
	always_comb begin
		if (mode_q) begin
			fdir_ra = dir_mul(sgn_corr(corr_ra_q), sgn_corr(CORR_W'(ref_ra)));
			fdir_dec = dir_neg(dir_mul(sgn_corr(corr_dec_q), sgn_corr(CORR_W'(ref_dec))));
		end else begin
			fdir_ra = sgn_corr(corr_ra_q);
			fdir_dec = sgn_corr(corr_dec_q);
		end
		fmag_ra = corr_ra_q[CORR_W-1] ? -corr_ra_q : corr_ra_q;
		fmag_dec = corr_dec_q[CORR_W-1] ? -corr_dec_q : corr_dec_q;
		fcl_ra = fmag_ra > CORR_W'(limits_q[31:0]);
		fcl_dec = fmag_dec > CORR_W'(limits_q[63:32]);
		if (!fcl_ra) frun_ra = '0;
		else if (ldir_ra_q == fdir_ra) frun_ra = run_ra_q + 2'd1;
		else frun_ra = run_ra_q;
		if (!fcl_dec) frun_dec = '0;
		else if (ldir_dec_q == fdir_dec) frun_dec = run_dec_q + 2'd1;
		else frun_dec = run_dec_q;
		flost = (frun_ra == CLAMP_RUN_LIMIT) || (frun_dec == CLAMP_RUN_LIMIT);
	end

	logic out_free;
	assign out_free = !result_valid || !result_stall;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			pgain_q <= 32'd66519;
			igain_q <= 32'd262;
			dgain_q <= 32'd7209;
			ref_q <= '0;
			racoef_q <= 64'd65536;
			deccoef_q <= 64'd65536;
			limits_q <= 64'd4294967297000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE: mode_q <= cfg_data[0];
				REG_PGAIN: pgain_q <= cfg_data[31:0];
				REG_IGAIN: igain_q <= cfg_data[31:0];
				REG_DGAIN: dgain_q <= cfg_data[31:0];
				REG_REF: ref_q <= cfg_data;
				REG_RACOEF: racoef_q <= cfg_data;
				REG_DECCOEF: deccoef_q <= cfg_data;
				REG_LIMITS: limits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// control and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= '0;
			cnt_q <= '0;
			integ_ra_q <= '0;
			integ_dec_q <= '0;
			last_ra_q <= '0;
			last_dec_q <= '0;
			run_ra_q <= '0;
			run_dec_q <= '0;
			ldir_ra_q <= DIR_NEG;
			ldir_dec_q <= DIR_NEG;
			result_valid <= 1'b0;
		end else begin
			if (result_valid && !result_stall && state_q != ST_FIN) result_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOAD;
						op_q <= '0;
						if (!mode_q) begin
							integ_ra_q <= is_ra;
							integ_dec_q <= is_dec;
							last_ra_q <= es_ra;
							last_dec_q <= es_dec;
						end
					end
				end
				ST_LOAD: begin
					cnt_q <= '0;
					state_q <= mode_q ? ST_DIV : ST_MUL;
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == MUL_LAST) state_q <= ST_ACC;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == DIV_LAST) state_q <= ST_ACC;
				end
				ST_ACC: begin
					op_q <= op_q + 4'd1;
					if ((mode_q && op_q == OP_DIV_DEC) || (!mode_q && op_q == OP_DEC_CN))
						state_q <= ST_FIN;
					else
						state_q <= ST_LOAD;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						result_valid <= 1'b1;
						if (flost) begin
							integ_ra_q <= '0;
							integ_dec_q <= '0;
							last_ra_q <= '0;
							last_dec_q <= '0;
							run_ra_q <= '0;
							run_dec_q <= '0;
							ldir_ra_q <= DIR_NEG;
							ldir_dec_q <= DIR_NEG;
						end else begin
							run_ra_q <= frun_ra;
							run_dec_q <= frun_dec;
							ldir_ra_q <= fdir_ra;
							ldir_dec_q <= fdir_dec;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				e_ra_q <= es_ra;
				e_dec_q <= es_dec;
				d_ra_q <= dra_w;
				d_dec_q <= ddec_w;
				diff_ra_q <= -e_ra_w;
				diff_dec_q <= -e_dec_w;
				sum_q <= '0;
			end
			ST_LOAD: begin
				g_sh_q <= g_sel;
				acc_hi_q <= '0;
				acc_lo_q <= '0;
				quo_q <= dnum[40] ? 41'(-dnum) : 41'(dnum);
				rem_q <= '0;
				divisor_q <= dslope[31] ? 32'(-dslope) : 32'(dslope);
				dneg_q <= dnum[40] ^ dslope[31];
			end
			ST_MUL: begin
				acc_hi_q <= msum[49:1];
				acc_lo_q <= {msum[0], acc_lo_q[31:1]};
				g_sh_q <= {1'b0, g_sh_q[31:1]};
			end
			ST_DIV: begin
				rem_q <= dge ? dtrial[31:0] : dshift[31:0];
				quo_q <= {quo_q[39:0], dge};
			end
			ST_ACC: begin
				if (mode_q) begin
					if (op_q == OP_DIV_RA) corr_ra_q <= qcorr;
					else corr_dec_q <= qcorr;
				end else begin
					case (op_q)
						OP_D_RA: begin u_ra_q <= usat; sum_q <= '0; end
						OP_D_DEC: begin u_dec_q <= usat; sum_q <= '0; end
						OP_RA_CN: begin corr_ra_q <= counts; sum_q <= '0; end
						OP_DEC_CN: begin corr_dec_q <= counts; sum_q <= '0; end
						default: sum_q <= nsum;
					endcase
				end
			end
			ST_FIN: begin
				if (out_free) begin
					lost_guide <= flost;
					ra_steps <= flost ? 32'd0 : (fcl_ra ? limits_q[31:0] : fmag_ra[31:0]);
					dec_steps <= flost ? 32'd0 : (fcl_dec ? limits_q[63:32] : fmag_dec[31:0]);
					ra_direction <= flost ? DIR_ZERO : fdir_ra;
					dec_direction <= flost ? DIR_ZERO : fdir_dec;
				end
			end
			default: ;
		endcase
	end

	`ASSERT_NEXT(a_accept_load, clk, arst_n, accept, state_q == ST_LOAD)
	`ASSERT_NOW(a_run_ra, clk, arst_n, 1'b1, run_ra_q < CLAMP_RUN_LIMIT)
	`ASSERT_NOW(a_run_dec, clk, arst_n, 1'b1, run_dec_q < CLAMP_RUN_LIMIT)
	`ASSERT_NOW(a_lost_zero, clk, arst_n, result_valid && lost_guide,
		ra_steps == 32'd0 && dec_steps == 32'd0)

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Guide PID limiter testbench
// Drives RA/DEC sample pairs through PID and slope modes across several
// register settings, predicts each correction item and checks it on arrival.
// ----------------------------------------------------------------------------
module testbench;
	import gpl_pkg::*;

	typedef struct {
		logic [31:0] ra;
		logic [31:0] dec;
	} sample_t;

	typedef struct {
		logic [31:0] ra_steps;
		logic [1:0]  ra_dir;
		logic [31:0] dec_steps;
		logic [1:0]  dec_dir;
		logic        lost;
	} corr_t;

	localparam longint I48_MAX = 64'sd140737488355327;
	localparam longint I48_MIN = -64'sd140737488355328;
	localparam longint U_LIM = 64'sd2147483647;
	localparam int WATCHDOG = 200000;

	logic clk = 0, arst_n = 0;
	logic sample_valid = 0, result_stall = 0, cfg_valid = 0;
	logic signed [31:0] ra_mean = 0, dec_mean = 0;
	logic [3:0] cfg_index = 0;
	logic [63:0] cfg_data = 0;
	logic sample_stall, result_valid, lost_guide, cfg_ready;
	logic [31:0] ra_steps, dec_steps;
	dir_t ra_direction, dec_direction;

	two_axis_guide_pid_limiter_top uut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// predictor state
	logic        m_mode;
	logic [31:0] m_pg, m_ig, m_dg;
	logic [63:0] m_ref, m_rac, m_decc, m_lim;
	longint      m_int_ra, m_int_dec, m_le_ra, m_le_dec;
	int          m_run_ra, m_run_dec, m_ld_ra, m_ld_dec;

	sample_t pending[$];
	corr_t   expected[$];
	int errors = 0, n_in = 0, n_out = 0, n_lost = 0, idle_cnt = 0;
	bit cfg_busy = 0, hold = 0;

	function automatic longint sat(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint gain_mul(logic [31:0] g, longint x);
		longint gs, hi, lo;
		gs = longint'($signed(g));
		hi = x >>> 16;
		lo = x - hi * 65536;
		return gs * hi + ((gs * lo) >>> 16);
	endfunction

	task automatic pid_axis(input longint r, input longint mn, inout longint integ,
			inout longint last, output longint u);
		longint e, d;
		e = sat(r - mn, -64'sd2147483648, 64'sd2147483647);
		integ = sat(integ + e, I48_MIN, I48_MAX);
		d = e - last;
		last = e;
		u = sat(gain_mul(m_pg, e) + gain_mul(m_ig, integ) + gain_mul(m_dg, d),
			-U_LIM, U_LIM);
	endtask

	function automatic longint to_counts(logic signed [95:0] s);
		logic signed [95:0] a;
		a = s < 0 ? -s : s;
		a = a >> 24;
		return s < 0 ? -longint'(a) : longint'(a);
	endfunction

	function automatic int sgn(longint v);
		return v > 0 ? 1 : (v < 0 ? -1 : 0);
	endfunction

	task automatic clamp_axis(input longint c, input int dir, input logic [31:0] lim,
			inout int run, inout int ld, output logic [31:0] mag);
		longint m;
		m = c < 0 ? -c : c;
		if (m > longint'({32'd0, lim})) begin
			m = longint'({32'd0, lim});
			if (ld == dir) run++;
		end else begin
			run = 0;
		end
		ld = dir;
		mag = m[31:0];
	endtask

	task automatic predict_correction(input sample_t s);
		longint rm, dm, rr, dr, rs, rc, ds, dc, rcorr, dcorr, ura, udec;
		int rd, dd;
		corr_t o;
		rm = longint'($signed(s.ra)); dm = longint'($signed(s.dec));
		rr = longint'($signed(m_ref[31:0])); dr = longint'($signed(m_ref[63:32]));
		rs = longint'($signed(m_rac[31:0])); rc = longint'($signed(m_rac[63:32]));
		ds = longint'($signed(m_decc[31:0])); dc = longint'($signed(m_decc[63:32]));
		if (m_mode) begin
			rcorr = rs == 0 ? 0 : ((rm - rr) * 256) / rs;
			dcorr = ds == 0 ? 0 : ((dm - dr) * 256) / ds;
			rd = sgn(rcorr) * sgn(rr);
			dd = -(sgn(dcorr) * sgn(dr));
		end else begin
			pid_axis(rr, rm, m_int_ra, m_le_ra, ura);
			pid_axis(dr, dm, m_int_dec, m_le_dec, udec);
			rcorr = to_counts(96'(ura) * 96'(rs) + 96'(udec) * 96'(rc));
			dcorr = to_counts(96'(ura) * 96'(ds) + 96'(udec) * 96'(dc));
			rd = sgn(rcorr); dd = sgn(dcorr);
		end
		clamp_axis(rcorr, rd, m_lim[31:0], m_run_ra, m_ld_ra, o.ra_steps);
		clamp_axis(dcorr, dd, m_lim[63:32], m_run_dec, m_ld_dec, o.dec_steps);
		o.ra_dir = rd[1:0]; o.dec_dir = dd[1:0]; o.lost = 1'b0;
		if (m_run_ra == 3 || m_run_dec == 3) begin
			m_int_ra = 0; m_int_dec = 0; m_le_ra = 0; m_le_dec = 0;
			m_run_ra = 0; m_run_dec = 0; m_ld_ra = -1; m_ld_dec = -1;
			o = '{0, 0, 0, 0, 1};
		end
		expected.push_back(o);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on result %0d: %s got %h expected %h", n_out, what, got, want);
		errors++;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// driver
	int send_gap = 0;
	always @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			predict_correction(pending.pop_front());
			n_in++;
			send_gap = gap_len();
		end
		if (!(sample_valid && sample_stall)) begin
			if (send_gap > 0) begin
				send_gap--;
				sample_valid <= 0;
			end else if (pending.size() > 0 && !cfg_busy && !hold) begin
				sample_valid <= 1;
				ra_mean <= pending[0].ra;
				dec_mean <= pending[0].dec;
			end else begin
				sample_valid <= 0;
			end
		end
	end

	// monitor
	int stall_gap = 0;
	always @(posedge clk) begin
		corr_t w;
		if (result_valid && !result_stall) begin
			n_out++;
			if (expected.size() == 0) begin
				$display("unexpected result %0d", n_out);
				errors++;
			end else begin
				w = expected.pop_front();
				if (ra_steps !== w.ra_steps) report_mismatch("ra_steps", ra_steps, w.ra_steps);
				if (ra_direction !== w.ra_dir) report_mismatch("ra_dir", ra_direction, w.ra_dir);
				if (dec_steps !== w.dec_steps) report_mismatch("dec_steps", dec_steps, w.dec_steps);
				if (dec_direction !== w.dec_dir)
					report_mismatch("dec_dir", dec_direction, w.dec_dir);
				if (lost_guide !== w.lost) report_mismatch("lost_guide", lost_guide, w.lost);
				if (w.lost) n_lost++;
			end
		end
		if (stall_gap > 0) begin
			stall_gap--;
			result_stall <= 1;
		end else begin
			stall_gap = gap_len();
			result_stall <= 0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG) begin
			$display("FAIL two_axis_guide_pid_limiter_top");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending.size() > 0 || sample_valid) @(posedge clk);
		while (expected.size() > 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [63:0] v);
		cfg_busy = 1;
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		case (idx)
			REG_MODE:    m_mode = v[0];
			REG_PGAIN:   m_pg = v[31:0];
			REG_IGAIN:   m_ig = v[31:0];
			REG_DGAIN:   m_dg = v[31:0];
			REG_REF:     m_ref = v;
			REG_RACOEF:  m_rac = v;
			REG_DECCOEF: m_decc = v;
			REG_LIMITS:  m_lim = v;
			default: ;
		endcase
		@(posedge clk);
		cfg_busy = 0;
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom;
			default: return 32'($signed($urandom_range(0, 20000)) - 10000);
		endcase
	endfunction

	task automatic push_sample(input logic [31:0] r, input logic [31:0] d);
		sample_t s;
		s.ra = r; s.dec = d;
		pending.push_back(s);
	endtask

	task automatic random_phase(input int n);
		repeat (n) push_sample(rand_word(), rand_word());
		wait_drained();
	endtask

	initial begin
		m_mode = 1'b0; m_pg = 32'd66519; m_ig = 32'd262; m_dg = 32'd7209; m_ref = 64'd0;
		m_rac = 64'd65536; m_decc = 64'd65536; m_lim = 64'd4294967297000;
		m_int_ra = 0; m_int_dec = 0; m_le_ra = 0; m_le_dec = 0;
		m_run_ra = 0; m_run_dec = 0; m_ld_ra = -1; m_ld_dec = -1;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// defaults: extremes, then same-direction overdrive to lose guide
		push_sample(32'h8000_0000, 32'h7fff_ffff);
		push_sample(32'h7fff_ffff, 32'h8000_0000);
		push_sample(32'd0, 32'd0);
		push_sample(32'hffff_ffff, 32'd1);
		repeat (4) push_sample(32'h8000_0000, 32'h8000_0000);
		wait_drained();

		write_reg(REG_LIMITS, {32'd5, 32'd3});
		write_reg(REG_REF, {32'hffff_f000, 32'h0000_1000});
		write_reg(REG_RACOEF, {32'h0000_8000, 32'hffff_0000});
		write_reg(REG_DECCOEF, {32'hffff_8000, 32'h0002_0000});
		repeat (6) push_sample(32'h0010_0000, 32'hfff0_0000);
		wait_drained();

		// slope mode: zero slope, signs of references, index beyond list
		write_reg(REG_MODE, 64'hffff_fffe_ffff_ffff);
		write_reg(REG_RACOEF, 64'd0);
		write_reg(4'd12, 64'h1);
		push_sample(32'h0000_4000, 32'h8000_0000);
		push_sample(32'h7fff_ffff, 32'h7fff_ffff);
		wait_drained();
		write_reg(REG_LIMITS, 64'hffff_ffff_ffff_ffff);
		write_reg(REG_RACOEF, {32'h7fff_ffff, 32'h0000_0001});
		write_reg(REG_DECCOEF, {32'h0, 32'h8000_0000});
		push_sample(32'h8000_0000, 32'h7fff_ffff);
		push_sample(32'h1234_5678, 32'h8765_4321);
		random_phase(60);

		write_reg(REG_LIMITS, {32'd40, 32'd40});
		write_reg(REG_DECCOEF, {32'h0, 32'h0000_0100});
		write_reg(REG_RACOEF, {32'h0, 32'hffff_ff00});
		random_phase(70);

		// PID mode, varied gains
		write_reg(REG_MODE, 64'd0);
		write_reg(REG_PGAIN, 64'(32'h8000_0000));
		write_reg(REG_IGAIN, 64'(32'h7fff_ffff));
		write_reg(REG_DGAIN, 64'(32'hffff_ffff));
		write_reg(REG_LIMITS, 64'hffff_ffff_ffff_ffff);
		random_phase(60);

		repeat (6) begin
			write_reg(REG_PGAIN, 64'(32'($urandom_range(0, 200000) - 100000)));
			write_reg(REG_IGAIN, 64'(32'($urandom_range(0, 4000) - 2000)));
			write_reg(REG_DGAIN, 64'(32'($urandom)));
			write_reg(REG_REF, {rand_word(), rand_word()});
			write_reg(REG_RACOEF, {32'($urandom_range(0, 1 << 18)), 32'($urandom)});
			write_reg(REG_DECCOEF, {32'($urandom), 32'($urandom_range(0, 1 << 18))});
			write_reg(REG_LIMITS, {32'($urandom_range(0, 2000)),
				32'($urandom_range(0, 2000))});
			push_sample(rand_word(), rand_word());
			// wait until this sample is sent and the result queue empties
			hold = 1;
			while (expected.size() > 0 || pending.size() > 0 || sample_valid) begin
				if (pending.size() > 0 && !sample_valid) hold = 0;
				@(posedge clk);
			end
			hold = 0;
			random_phase(55);
		end

		$display("covered %0d samples in, %0d corrections out, %0d lost-guide events",
			n_in, n_out, n_lost);
		if (errors == 0) begin
			$display("PASS two_axis_guide_pid_limiter_top");
		end else begin
			$display("FAIL two_axis_guide_pid_limiter_top");
		end
		$finish;
	end
endmodule
